/* src/assert_macros.svh */
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the dimmer fade controller checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dfc_pkg.sv */
// ============================================================================
// Dimmer fade controller package
// Widths, codes, reset values and word types shared by the controller files.
// ============================================================================
`default_nettype none

package dfc_pkg;

    localparam int LEVEL_W    = 7;
    localparam int REQ_W      = 3;
    localparam int MODE_W     = 3;
    localparam int PERIOD_W   = 24;
    localparam int TPS_W      = 16;
    localparam int RAMP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int LEVEL_TOP_DEF      = 100;
    localparam int CYCLIC_DIVIDER_DEF = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd30;
    localparam logic [TPS_W-1:0]   TPS_RESET   = 16'd128;

    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ON     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OFF    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CYC    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_STOP   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEEK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CYCLIC = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TPS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [LEVEL_W-1:0] target_level;
    } dfc_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_level;
        logic               lamp_on;
        logic               busy_res;
        logic [MODE_W-1:0]  fade_mode;
        logic [LEVEL_W-1:0] full_level;
    } dfc_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;
        logic load_out;
    } dfc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_needed;
        logic div_done;
    } dfc_status_t;

endpackage

`default_nettype wire

/* src/dimmer_fade_controller.sv */
// A tick or a command that starts no ramp goes from the state update at acceptance
// through the emit state into the output register, waiting there while a stalled result
// is held; a word that starts an on, off or set ramp first waits in the divide state for
// the 24-step one-bit-per-cycle step period divider. The next word is taken once loaded.
// Reset puts the level, full and settled levels at 30, the lamp enabled, the mode idle,
// and the registers at 128 ticks per second, zero ramp time and zero minimum level.
// ============================================================================
// Dimmer fade controller
// Top level: a sequencer and a datapath that fade a lamp drive level by steps.
// ============================================================================
`default_nettype none

module dimmer_fade_controller
    import dfc_pkg::*;
#(
    parameter int LEVEL_TOP      = LEVEL_TOP_DEF,
    parameter int CYCLIC_DIVIDER = CYCLIC_DIVIDER_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire dfc_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output dfc_out_t                   out_data,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The sequencer accepts one word at a time. Every word updates the state once,
    // at acceptance; a word that starts an on, off or set ramp also starts the
    // divider, and the step period is written when the divider finishes. A cyclic
    // start takes its period from a constant reciprocal multiply at acceptance.
    // The result word is then a snapshot of the state, held in the output register.
    // The next word may be accepted while that result still waits to be taken.
    dfc_cmd_t    cmd;
    dfc_status_t status;

    dfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the levels, the tick counter, the configuration
    // registers and the divider that produces ramp step periods.
    dfc_datapath #(
        .LEVEL_TOP      (LEVEL_TOP),
        .CYCLIC_DIVIDER (CYCLIC_DIVIDER)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* src/dfc_div.sv */
// ============================================================================
// Step period divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ============================================================================
`default_nettype none

module dfc_div
    import dfc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [PERIOD_W-1:0] dividend,
    input  wire logic [LEVEL_W-1:0]  divisor,
    output logic                     done,
    output logic [PERIOD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(PERIOD_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PERIOD_W-1:0] q_reg;
    logic [LEVEL_W-1:0] rem_reg;
    logic [LEVEL_W-1:0] dvs_reg;
    logic               zero_reg;

    logic [LEVEL_W:0]   trial;
    logic [LEVEL_W:0]   diff;
    logic               fits;

    assign trial = {rem_reg, q_reg[PERIOD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(PERIOD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[PERIOD_W-2:0], fits};
            rem_reg <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : q_reg;

endmodule

`default_nettype wire

/* src/dfc_ctrl.sv */
// ============================================================================
// Dimmer fade controller sequencer
// Takes one word, waits for the divider when needed, then loads the result.
// ============================================================================
`default_nettype none

module dfc_ctrl
    import dfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire dfc_status_t status,
    output dfc_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.apply      = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = status.div_needed ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/dfc_datapath.sv */
// ============================================================================
// Dimmer fade controller datapath
// Level state, stepping logic, configuration registers and result register.
// ============================================================================
`default_nettype none

module dfc_datapath
    import dfc_pkg::*;
#(
    parameter int LEVEL_TOP      = LEVEL_TOP_DEF,
    parameter int CYCLIC_DIVIDER = CYCLIC_DIVIDER_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dfc_cmd_t              cmd,
    output dfc_status_t                status,
    input  wire dfc_in_t               in_data,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output dfc_out_t                   out_data
);

    localparam logic [LEVEL_W-1:0] TOP = LEVEL_W'(LEVEL_TOP);

    // The cyclic step period is ticks per second over a constant divider, taken
    // as a multiply by a rounded-up reciprocal and a shift; with the shift at
    // the dividend width plus the divider's ceiling log2 it is exact for every
    // 16-bit dividend.
    localparam int CYC_SH = TPS_W + $clog2(CYCLIC_DIVIDER);
    localparam int MUL_W  = TPS_W + 1;
    localparam int PROD_W = TPS_W + MUL_W;
    localparam logic [MUL_W-1:0] CYC_MUL =
        MUL_W'((64'd1 << CYC_SH) / 64'(CYCLIC_DIVIDER) + 64'd1);

    logic [TPS_W-1:0]    tps_reg;
    logic [RAMP_W-1:0]   ramp_time_reg;
    logic [LEVEL_W-1:0]  min_level_reg;

    logic [LEVEL_W-1:0]  level_now_reg, level_now_next;
    logic [LEVEL_W-1:0]  level_full_reg, level_full_next;
    logic [LEVEL_W-1:0]  level_settled_reg, level_settled_next;
    logic                enabled_reg, enabled_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [PERIOD_W-1:0] step_period_reg;
    logic [PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic [LEVEL_W-1:0]  seek_level_reg, seek_level_next;
    logic                seek_upward_reg, seek_upward_next;
    logic                stop_pending_reg, stop_pending_next;
    dfc_out_t            out_reg;

    logic [LEVEL_W-1:0]  tgt;
    logic [LEVEL_W-1:0]  lvl_up;
    logic [LEVEL_W-1:0]  lvl_dn;
    logic [LEVEL_W-1:0]  lvl_seek;
    logic [LEVEL_W-1:0]  lvl_cyc;
    logic [LEVEL_W-1:0]  full_diff;
    logic [PERIOD_W-1:0] tick_inc;
    logic [PERIOD_W-1:0] ramp_prod;
    logic [PROD_W-1:0]   cyc_prod;
    logic [PERIOD_W-1:0] cyc_period;
    logic [REQ_W-1:0]    req_eff;
    logic                div_start_c;
    logic                cyc_load_c;
    logic                div_done;
    logic [PERIOD_W-1:0] div_q;
    logic [PERIOD_W-1:0] div_dividend;
    logic [LEVEL_W-1:0]  div_divisor;

    assign tgt       = (in_data.target_level > TOP) ? TOP : in_data.target_level;
    assign lvl_up    = (level_now_reg < TOP) ? level_now_reg + LEVEL_W'(1) : level_now_reg;
    assign lvl_dn    = (level_now_reg != '0) ? level_now_reg - LEVEL_W'(1) : level_now_reg;
    assign lvl_seek  = seek_upward_reg ? lvl_up : lvl_dn;
    assign lvl_cyc   = enabled_reg ? lvl_dn : lvl_up;
    assign full_diff = (level_full_reg >= min_level_reg) ? level_full_reg - min_level_reg
                                                         : min_level_reg - level_full_reg;
    assign tick_inc  = tick_count_reg + PERIOD_W'(1);
    assign ramp_prod = PERIOD_W'(tps_reg) * PERIOD_W'(ramp_time_reg);
    assign cyc_prod   = PROD_W'(tps_reg) * PROD_W'(CYC_MUL);
    assign cyc_period = PERIOD_W'(cyc_prod >> CYC_SH);

    always_comb
    begin
        level_now_next     = level_now_reg;
        level_full_next    = level_full_reg;
        level_settled_next = level_settled_reg;
        enabled_next       = enabled_reg;
        mode_next          = mode_reg;
        tick_count_next    = tick_count_reg;
        seek_level_next    = seek_level_reg;
        seek_upward_next   = seek_upward_reg;
        stop_pending_next  = stop_pending_reg;
        div_start_c        = 1'b0;
        cyc_load_c         = 1'b0;

        // A toggle acts as off while the lamp is enabled and as on otherwise.
        req_eff = in_data.req_type;
        if (in_data.req_type == REQ_TOGGLE)
        begin
            req_eff = enabled_reg ? REQ_OFF : REQ_ON;
        end

        priority if (in_data.req_type == REQ_TICK)
        begin
            if (mode_reg != MODE_IDLE)
            begin
                if (tick_inc >= step_period_reg)
                begin
                    tick_count_next = '0;
                    unique case (mode_reg)
                        MODE_UP:
                        begin
                            level_now_next = lvl_up;
                            if (lvl_up >= level_full_reg || lvl_up >= TOP)
                            begin
                                level_settled_next = level_full_reg;
                                enabled_next       = 1'b1;
                                mode_next          = MODE_IDLE;
                            end
                        end
                        MODE_DOWN:
                        begin
                            level_now_next = lvl_dn;
                            if (lvl_dn <= min_level_reg)
                            begin
                                level_settled_next = min_level_reg;
                                enabled_next       = 1'b0;
                                mode_next          = MODE_IDLE;
                            end
                        end
                        MODE_SEEK:
                        begin
                            level_now_next = lvl_seek;
                            if (lvl_seek == seek_level_reg)
                            begin
                                level_settled_next = seek_level_reg;
                                level_full_next    = seek_level_reg;
                                enabled_next       = 1'b1;
                                mode_next          = MODE_IDLE;
                            end
                        end
                        MODE_CYCLIC:
                        begin
                            level_now_next = lvl_cyc;
                            if (lvl_cyc == '0)
                            begin
                                enabled_next = 1'b0;
                            end
                            else if (lvl_cyc >= TOP)
                            begin
                                enabled_next = 1'b1;
                            end
                            // A pending stop ends the run on this step.
                            if (stop_pending_reg)
                            begin
                                level_full_next   = lvl_cyc;
                                enabled_next      = (lvl_cyc != '0);
                                stop_pending_next = 1'b0;
                                mode_next         = MODE_IDLE;
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
        end
        else if (in_data.req_type == REQ_STOP)
        begin
            if (mode_reg == MODE_CYCLIC)
            begin
                stop_pending_next = 1'b1;
            end
        end
        else if (mode_reg == MODE_IDLE)
        begin
            unique case (req_eff)
                REQ_ON:
                begin
                    if (!enabled_reg)
                    begin
                        if (level_now_reg >= level_full_reg || level_now_reg >= TOP)
                        begin
                            level_settled_next = level_full_reg;
                            enabled_next       = 1'b1;
                        end
                        else
                        begin
                            mode_next       = MODE_UP;
                            tick_count_next = '0;
                            div_start_c     = 1'b1;
                        end
                    end
                end
                REQ_OFF:
                begin
                    if (enabled_reg)
                    begin
                        if (level_now_reg <= min_level_reg)
                        begin
                            level_settled_next = min_level_reg;
                            enabled_next       = 1'b0;
                        end
                        else
                        begin
                            mode_next       = MODE_DOWN;
                            tick_count_next = '0;
                            div_start_c     = 1'b1;
                        end
                    end
                end
                REQ_SET:
                begin
                    if (tgt != level_settled_reg)
                    begin
                        seek_level_next  = tgt;
                        seek_upward_next = (tgt > level_now_reg);
                        if (tgt == level_now_reg)
                        begin
                            level_settled_next = tgt;
                            level_full_next    = tgt;
                            enabled_next       = 1'b1;
                        end
                        else
                        begin
                            mode_next       = MODE_SEEK;
                            tick_count_next = '0;
                            div_start_c     = 1'b1;
                        end
                    end
                end
                REQ_CYC:
                begin
                    stop_pending_next = 1'b0;
                    mode_next         = MODE_CYCLIC;
                    tick_count_next   = '0;
                    cyc_load_c        = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
        end
    end

    assign div_dividend = ramp_prod;
    assign div_divisor  = full_diff;

    dfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.apply && div_start_c),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.div_needed = div_start_c;
    assign status.div_done   = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg           <= TPS_RESET;
            ramp_time_reg     <= '0;
            min_level_reg     <= '0;
            level_now_reg     <= LEVEL_RESET;
            level_full_reg    <= LEVEL_RESET;
            level_settled_reg <= LEVEL_RESET;
            enabled_reg       <= 1'b1;
            mode_reg          <= MODE_IDLE;
            step_period_reg   <= '0;
            tick_count_reg    <= '0;
            seek_level_reg    <= '0;
            seek_upward_reg   <= 1'b0;
            stop_pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_TPS:  tps_reg       <= cfg_data[TPS_W-1:0];
                    CFG_RAMP: ramp_time_reg <= cfg_data[RAMP_W-1:0];
                    CFG_MIN:  min_level_reg <= cfg_data[LEVEL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.apply)
            begin
                level_now_reg     <= level_now_next;
                level_full_reg    <= level_full_next;
                level_settled_reg <= level_settled_next;
                enabled_reg       <= enabled_next;
                mode_reg          <= mode_next;
                tick_count_reg    <= tick_count_next;
                seek_level_reg    <= seek_level_next;
                seek_upward_reg   <= seek_upward_next;
                stop_pending_reg  <= stop_pending_next;
            end
            if (div_done)
            begin
                step_period_reg <= div_q;
            end
            else if (cmd.apply && cyc_load_c)
            begin
                step_period_reg <= cyc_period;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.drive_level <= level_now_reg;
            out_reg.lamp_on     <= enabled_reg;
            out_reg.busy_res    <= (mode_reg != MODE_IDLE);
            out_reg.fade_mode   <= mode_reg;
            out_reg.full_level  <= level_full_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

/* src/dfc_checker.sv */
// ============================================================================
// Dimmer fade controller checker
// Port-level assertions on result words and both handshakes.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module dfc_checker
    import dfc_pkg::*;
#(
    parameter int LEVEL_TOP = LEVEL_TOP_DEF
)
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_stall,
    input wire logic     out_valid,
    input wire logic     out_stall,
    input wire dfc_out_t out_data
);

    localparam logic [LEVEL_W-1:0] TOP = LEVEL_W'(LEVEL_TOP);

    `ASSERT_SAME(a_busy_mode, clk, rst_n, out_valid, out_data.busy_res == (out_data.fade_mode != MODE_IDLE), "busy flag disagrees with fade mode")
    `ASSERT_SAME(a_level_top, clk, rst_n, out_valid, (out_data.drive_level <= TOP) && (out_data.full_level <= TOP), "level above the top level")
    `ASSERT_SAME(a_mode_range, clk, rst_n, out_valid, out_data.fade_mode <= MODE_CYCLIC, "fade mode out of range")
    `ASSERT_NEXT(a_one_word, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while a word is at work")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result word changed")

endmodule

bind dimmer_fade_controller dfc_checker #(
    .LEVEL_TOP (LEVEL_TOP)
) u_dfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

/* tb/dfc_fade_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// Dimmer fade checker
// Watches the request, result and register ports of the fade controller,
// predicts every result word from its own copy of the dimmer state and
// compares each accepted result word with the oldest prediction.
// ============================================================================

module dfc_fade_checker
    import dfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  dfc_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  dfc_out_t              out_data,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    words_owed
);

    localparam logic [LEVEL_W-1:0] TOP_LVL = LEVEL_W'(LEVEL_TOP_DEF);

    // Register copies.
    logic [TPS_W-1:0]    tps_reg;
    logic [RAMP_W-1:0]   ramp_reg;
    logic [LEVEL_W-1:0]  min_reg;

    // Dimmer state copy.
    logic [LEVEL_W-1:0]  lvl;
    logic [LEVEL_W-1:0]  on_lvl;
    logic [LEVEL_W-1:0]  rest_lvl;
    logic                lit;
    logic [MODE_W-1:0]   fade;
    logic [PERIOD_W-1:0] step_ticks;
    logic [PERIOD_W-1:0] tick_acc;
    logic [LEVEL_W-1:0]  goal_lvl;
    logic                goal_above;
    logic                stop_req;

    dfc_out_t awaited_words[$];

    // Ticks per one-level step for a ramp, latched when the ramp starts.
    function automatic logic [PERIOD_W-1:0] fade_step_ticks();
        int unsigned span;
        int unsigned whole;
        span  = (on_lvl >= min_reg) ? on_lvl - min_reg : min_reg - on_lvl;
        whole = 32'(tps_reg) * 32'(ramp_reg);
        if (span == 0)
        begin
            return '0;
        end
        return PERIOD_W'(whole / span);
    endfunction

    function automatic void begin_fade(logic [MODE_W-1:0] mode, logic [PERIOD_W-1:0] period);
        fade       = mode;
        step_ticks = period;
        tick_acc   = '0;
    endfunction

    function automatic void reach_full();
        rest_lvl = on_lvl;
        lit      = 1'b1;
        fade     = MODE_IDLE;
    endfunction

    function automatic void reach_min();
        rest_lvl = min_reg;
        lit      = 1'b0;
        fade     = MODE_IDLE;
    endfunction

    function automatic void reach_goal();
        rest_lvl = goal_lvl;
        on_lvl   = goal_lvl;
        lit      = 1'b1;
        fade     = MODE_IDLE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        dfc_out_t           want;
        dfc_out_t           got;
        logic [REQ_W-1:0]   req;
        logic [LEVEL_W-1:0] goal;
        if (!rst_n)
        begin
            tps_reg    = TPS_RESET;
            ramp_reg   = '0;
            min_reg    = '0;
            lvl        = LEVEL_RESET;
            on_lvl     = LEVEL_RESET;
            rest_lvl   = LEVEL_RESET;
            lit        = 1'b1;
            fade       = MODE_IDLE;
            step_ticks = '0;
            tick_acc   = '0;
            goal_lvl   = '0;
            goal_above = 1'b0;
            stop_req   = 1'b0;
            awaited_words.delete();
            fail_count = 0;
            words_owed <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_TPS:  tps_reg = cfg_data;
                    CFG_RAMP: ramp_reg = cfg_data[RAMP_W-1:0];
                    CFG_MIN:  min_reg = cfg_data[LEVEL_W-1:0];
                    default:  ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (awaited_words.size() == 0)
                begin
                    $error("result word with no prediction waiting: %h", got);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (got.drive_level !== want.drive_level)
                    begin
                        $error("drive_level: expected %0d, got %0d",
                               want.drive_level, got.drive_level);
                        fail_count = fail_count + 1;
                    end
                    if (got.lamp_on !== want.lamp_on)
                    begin
                        $error("lamp_on: expected %0d, got %0d", want.lamp_on, got.lamp_on);
                        fail_count = fail_count + 1;
                    end
                    if (got.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                        fail_count = fail_count + 1;
                    end
                    if (got.fade_mode !== want.fade_mode)
                    begin
                        $error("fade_mode: expected %0d, got %0d",
                               want.fade_mode, got.fade_mode);
                        fail_count = fail_count + 1;
                    end
                    if (got.full_level !== want.full_level)
                    begin
                        $error("full_level: expected %0d, got %0d",
                               want.full_level, got.full_level);
                        fail_count = fail_count + 1;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                req  = in_data.req_type;
                goal = (in_data.target_level > TOP_LVL) ? TOP_LVL : in_data.target_level;
                if (req == REQ_TICK)
                begin
                    if (fade != MODE_IDLE)
                    begin
                        tick_acc = tick_acc + 1'b1;
                        if (tick_acc >= step_ticks)
                        begin
                            tick_acc = '0;
                            case (fade)
                                MODE_UP:
                                begin
                                    if (lvl < TOP_LVL)
                                        lvl = lvl + 1'b1;
                                    if (lvl >= on_lvl || lvl >= TOP_LVL)
                                        reach_full();
                                end
                                MODE_DOWN:
                                begin
                                    if (lvl != 0)
                                        lvl = lvl - 1'b1;
                                    if (lvl <= min_reg)
                                        reach_min();
                                end
                                MODE_SEEK:
                                begin
                                    if (goal_above)
                                    begin
                                        if (lvl < TOP_LVL)
                                            lvl = lvl + 1'b1;
                                    end
                                    else if (lvl != 0)
                                    begin
                                        lvl = lvl - 1'b1;
                                    end
                                    if (lvl == goal_lvl)
                                        reach_goal();
                                end
                                MODE_CYCLIC:
                                begin
                                    // Falls while lit, rises while dark, flips at the ends.
                                    if (lit)
                                    begin
                                        if (lvl != 0)
                                            lvl = lvl - 1'b1;
                                    end
                                    else if (lvl < TOP_LVL)
                                    begin
                                        lvl = lvl + 1'b1;
                                    end
                                    if (lvl == 0)
                                        lit = 1'b0;
                                    else if (lvl >= TOP_LVL)
                                        lit = 1'b1;
                                    if (stop_req)
                                    begin
                                        on_lvl   = lvl;
                                        lit      = (lvl != 0);
                                        stop_req = 1'b0;
                                        fade     = MODE_IDLE;
                                    end
                                end
                                default: fade = MODE_IDLE;
                            endcase
                        end
                    end
                end
                else if (req == REQ_STOP)
                begin
                    if (fade == MODE_CYCLIC)
                        stop_req = 1'b1;
                end
                else if (fade == MODE_IDLE)
                begin
                    if (req == REQ_TOGGLE)
                        req = lit ? REQ_OFF : REQ_ON;
                    case (req)
                        REQ_ON:
                        begin
                            if (!lit)
                            begin
                                if (lvl >= on_lvl || lvl >= TOP_LVL)
                                    reach_full();
                                else
                                    begin_fade(MODE_UP, fade_step_ticks());
                            end
                        end
                        REQ_OFF:
                        begin
                            if (lit)
                            begin
                                if (lvl <= min_reg)
                                    reach_min();
                                else
                                    begin_fade(MODE_DOWN, fade_step_ticks());
                            end
                        end
                        REQ_SET:
                        begin
                            // The direction comes from the live level, not the settled one.
                            if (goal != rest_lvl)
                            begin
                                goal_lvl   = goal;
                                goal_above = (goal > lvl);
                                if (goal == lvl)
                                    reach_goal();
                                else
                                    begin_fade(MODE_SEEK, fade_step_ticks());
                            end
                        end
                        REQ_CYC:
                        begin
                            stop_req = 1'b0;
                            begin_fade(MODE_CYCLIC,
                                       PERIOD_W'(tps_reg / TPS_W'(CYCLIC_DIVIDER_DEF)));
                        end
                        default: ;
                    endcase
                end

                want.drive_level = lvl;
                want.lamp_on     = lit;
                want.busy_res    = (fade != MODE_IDLE);
                want.fade_mode   = fade;
                want.full_level  = on_lvl;
                awaited_words.push_back(want);
            end

            words_owed <= awaited_words.size();
        end
    end

endmodule

/* tb/tb_dimmer_fade_controller.sv */
`timescale 1ns / 1ps
// ============================================================================
// Dimmer fade controller testbench
// Drives ticks and dimmer commands through the request channel under random
// gaps and result back-pressure, reprograms the fade registers between
// phases, and lets a separate checker predict and compare every result word.
// ============================================================================

module tb_dimmer_fade_controller;
    import dfc_pkg::*;

    // Index past the last register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Request code outside the command set; the block must ignore it.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 160;
    // The tail wait covers the time a ramp-starting word takes, with margin.
    localparam int SETTLE_CYCLES   = 40;
    // Watchdog limit; the slowest correct run stays well under it.
    localparam int CYCLE_LIMIT     = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    dfc_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    dfc_out_t              out_data;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int words_owed;
    int cycle_count = 0;
    // Longest wait either side may draw before its next word; zero gives
    // stretches where both channels run flat out.
    int idle_max = 5;

    // Register settings of the random phases.  They cover both ends of every
    // register while keeping step periods short enough that fades complete.
    int unsigned phase_tps[PHASES];
    int unsigned phase_ramp[PHASES];
    int unsigned phase_floor[PHASES];
    bit          phase_cyclic[PHASES];

    dimmer_fade_controller dut (.*);

    dfc_fade_checker fade_chk (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** dimmer_fade_controller: FAILED **");
            $finish;
        end
    end

    // Result side: before each word it holds stall high for a random number
    // of cycles, then takes the next word that shows up.
    initial
    begin : result_sink
        int hold;
        forever
        begin
            hold = $urandom_range(idle_max);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
        end
    end

    // Offers one request word after a random gap and returns at the edge that
    // accepts it.  Valid stays high afterwards so a zero gap keeps it asserted
    // without a drop; a nonzero gap lowers it first.
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [LEVEL_W-1:0] tgt);
        int gap;
        gap = $urandom_range(idle_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{req_type: req, target_level: tgt};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stops offering words and waits until every predicted result word has
    // been taken.  The first edge lets the checker's count catch up with the
    // word accepted last.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    // Registers only change while no word is in flight.
    task automatic apply_setting(input int unsigned tps, input int unsigned ramp,
                                 input int unsigned floor_lvl);
        drain();
        write_reg(CFG_TPS, tps);
        write_reg(CFG_RAMP, ramp);
        write_reg(CFG_MIN, floor_lvl);
        cfg_wen <= 1'b0;
    endtask

    // Random traffic: mostly ticks so that fades and cyclic runs actually
    // step to their ends, with every command mixed in.  Stops are kept rare
    // so that cyclic runs live long enough to bounce off both ends.
    task automatic send_random_words(input int count, input bit cyclic_ok);
        int                 pick;
        logic [REQ_W-1:0]   req;
        logic [LEVEL_W-1:0] tgt;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            tgt  = LEVEL_W'($urandom_range(127));
            if (pick < 65)
                req = REQ_TICK;
            else if (pick < 70)
                req = REQ_TOGGLE;
            else if (pick < 74)
                req = REQ_ON;
            else if (pick < 79)
                req = REQ_OFF;
            else if (pick < 89)
                req = REQ_SET;
            else if (pick < 93)
                req = cyclic_ok ? REQ_CYC : REQ_TICK;
            else if (pick < 97)
                req = REQ_STOP;
            else
                req = REQ_UNUSED;
            // Set targets mostly stay in range; the rest exercise saturation.
            if (req == REQ_SET && $urandom_range(9) != 0)
                tgt = LEVEL_W'($urandom_range(100));
            send_word(req, tgt);
        end
    endtask

    initial
    begin
        phase_tps    = '{128, 1,   65535, 10, 25, 7,  40, 3};
        phase_ramp   = '{0,   255, 0,     3,  1,  0,  2,  9};
        phase_floor  = '{0,   100, 0,     20, 5,  60, 10, 0};
        // A cyclic run at the top tick rate would need thousands of ticks per
        // step, so that phase leaves cyclic starts out.
        phase_cyclic = '{1,   1,   0,     1,  1,  1,  1,  1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part.  A minimum of 29 right under the reset level of 30
        // keeps every fade here a step or two long, and 10 ticks per second
        // makes a cyclic run step on every tick.
        write_reg(CFG_SPARE, 16'hFFFF);
        apply_setting(10, 0, 29);

        // Requests that must change nothing: a tick while idle, on while on,
        // a stop with no cyclic run, the unused code, set to the settled level.
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_ON, 7'd0);
        send_word(REQ_STOP, 7'd0);
        send_word(REQ_UNUSED, 7'h7F);
        send_word(REQ_SET, 7'd30);
        // One-step seek upward; the off in between is dropped while busy.
        send_word(REQ_SET, 7'd31);
        send_word(REQ_OFF, 7'd0);
        send_word(REQ_TICK, 7'd0);
        // Toggle as off, ramping down to the minimum, then off while off and
        // a set to the settled level, both ignored.
        send_word(REQ_TOGGLE, 7'd0);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_OFF, 7'd0);
        send_word(REQ_SET, 7'd29);
        // Toggle as on, ramping back up to the full level.
        send_word(REQ_TOGGLE, 7'd0);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_TICK, 7'd0);
        // Cyclic run: a set while busy is ignored, and the stop ends the run
        // on the following step, leaving the settled level behind.
        send_word(REQ_CYC, 7'd0);
        send_word(REQ_SET, 7'd50);
        send_word(REQ_TICK, 7'd0);
        send_word(REQ_STOP, 7'd0);
        send_word(REQ_TICK, 7'd0);
        // Set to the live level completes at once; off and on that are
        // already at their targets complete at once as well.
        send_word(REQ_SET, 7'd29);
        send_word(REQ_OFF, 7'd0);
        send_word(REQ_ON, 7'd0);
        // Target above the top saturates; full equals minimum, so the step
        // period comes from a zero divisor.
        send_word(REQ_SET, 7'd127);

        for (int p = 0; p < PHASES; p++)
        begin
            idle_max = (p % 3 == 1) ? 0 : 5;
            apply_setting(phase_tps[p], phase_ramp[p], phase_floor[p]);
            send_random_words(WORDS_PER_PHASE, phase_cyclic[p]);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && words_owed == 0)
        begin
            $display("** dimmer_fade_controller: PASSED **");
        end
        else
        begin
            $display("** dimmer_fade_controller: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/dfc_pkg.sv
src/dfc_div.sv
src/dfc_ctrl.sv
src/dfc_datapath.sv
src/dimmer_fade_controller.sv
src/dfc_checker.sv
tb/dfc_fade_checker.sv
tb/tb_dimmer_fade_controller.sv
